>>> rtl/stb_pkg.sv
package stb_pkg;

  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_SET  = 2'd1;
  localparam logic [1:0] OP_GET  = 2'd2;

  localparam int unsigned CFG_W    = 9;
  localparam int unsigned ID_W     = 8;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned MILLIS_W = 10;
  localparam int unsigned PRE_W    = 8;

  localparam logic [CFG_W-1:0]    PERIOD_RESET = 9'd10;
  localparam logic [CFG_W-1:0]    PERIOD_MAX   = 9'd256;
  localparam logic [MILLIS_W-1:0] MILLIS_WRAP  = 10'd999;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SWEEP,
    S_DONE
  } stb_state_e;

  typedef struct packed {
    logic accept;
    logic sweep_run;
    logic load;
  } stb_cmd_t;

  typedef struct packed {
    logic is_tick;
    logic sweep_done;
  } stb_status_t;

endpackage

>>> rtl/stb_ram.sv
module stb_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 8
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic                                    re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/stb_ctrl.sv
module stb_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  stb_pkg::stb_status_t status_i,
  output stb_pkg::stb_cmd_t    cmd_o
);

  import stb_pkg::*;

  stb_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    in_ready_o    = 1'b0;
    out_valid_d   = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = status_i.is_tick ? S_SWEEP : S_DONE;
        end
      end
      S_SWEEP: begin
        cmd_o.sweep_run = 1'b1;
        if (status_i.sweep_done) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        // The result register is free once its current transaction completes.
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> rtl/stb_datapath.sv
module stb_datapath #(
  parameter int unsigned NUM_TIMERS = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [stb_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic [1:0]                    opcode_i,
  input  logic [stb_pkg::ID_W-1:0]      timer_id_i,
  input  logic [stb_pkg::DATA_W-1:0]    write_value_i,
  input  stb_pkg::stb_cmd_t             cmd_i,
  output stb_pkg::stb_status_t          status_o,
  output logic                          ok_o,
  output logic [stb_pkg::DATA_W-1:0]    read_value_o,
  output logic                          action_due_o,
  output logic [stb_pkg::DATA_W-1:0]    seconds_count_o,
  output logic [stb_pkg::DATA_W-1:0]    tick_count_o
);

  import stb_pkg::*;

  localparam int unsigned ADDR_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int unsigned CNT_W  = $clog2(NUM_TIMERS + 1);

  // Configuration and free-running counters.
  logic [CFG_W-1:0]    period_q;
  logic [PRE_W-1:0]    prescale_q, prescale_d;
  logic [MILLIS_W-1:0] millis_q, millis_d;
  logic [DATA_W-1:0]   seconds_q, seconds_d;
  logic [DATA_W-1:0]   ticks_q, ticks_d;
  logic                due_q, due_d;

  // Operation held while it is in progress.
  logic [1:0] op_q;
  logic       idv_q;
  logic       id_valid;

  // Timer store control.
  logic [NUM_TIMERS-1:0] valid_q;
  logic [CNT_W-1:0]      cnt_q;
  logic                  wb_valid_q;
  logic [ADDR_W-1:0]     wb_idx_q;
  logic                  rvalid_q;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [DATA_W-1:0] ram_rdata;
  logic [DATA_W-1:0] entry_value;
  logic              sweep_issue;

  logic [CFG_W-1:0] period_eff;
  logic [CFG_W-1:0] period_m1_full;
  logic [PRE_W-1:0] period_m1;

  logic              ok_q;
  logic [DATA_W-1:0] read_value_q;
  logic              action_due_q;
  logic [DATA_W-1:0] seconds_out_q;
  logic [DATA_W-1:0] ticks_out_q;

  assign id_valid = timer_id_i < ID_W'(NUM_TIMERS);

  always_comb begin
    if (period_q == '0) begin
      period_eff = CFG_W'(1);
    end else if (period_q > PERIOD_MAX) begin
      period_eff = PERIOD_MAX;
    end else begin
      period_eff = period_q;
    end
    period_m1_full = period_eff - CFG_W'(1);
    period_m1      = period_m1_full[PRE_W-1:0];
  end

  always_comb begin
    prescale_d = prescale_q;
    millis_d   = millis_q;
    seconds_d  = seconds_q;
    ticks_d    = ticks_q;
    due_d      = due_q;
    if (cmd_i.accept) begin
      due_d = 1'b0;
      if (opcode_i == OP_TICK) begin
        ticks_d = ticks_q + DATA_W'(1);
        if (prescale_q < period_m1) begin
          prescale_d = prescale_q + PRE_W'(1);
        end else begin
          prescale_d = '0;
          due_d      = 1'b1;
        end
        if (millis_q >= MILLIS_WRAP) begin
          millis_d  = '0;
          seconds_d = seconds_q + DATA_W'(1);
        end else begin
          millis_d = millis_q + MILLIS_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q   <= PERIOD_RESET;
      prescale_q <= '0;
      millis_q   <= '0;
      seconds_q  <= '0;
      ticks_q    <= '0;
      due_q      <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        period_q <= cfg_wdata_i;
      end
      prescale_q <= prescale_d;
      millis_q   <= millis_d;
      seconds_q  <= seconds_d;
      ticks_q    <= ticks_d;
      due_q      <= due_d;
    end
  end

  // The sweep reads one timer per cycle and writes the decremented count
  // back in the next cycle, while the next timer is being read.
  assign sweep_issue = cmd_i.sweep_run && (cnt_q < CNT_W'(NUM_TIMERS));
  assign entry_value = rvalid_q ? ram_rdata : '0;

  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = cnt_q[ADDR_W-1:0];
    if (sweep_issue) begin
      ram_re = 1'b1;
    end else if (cmd_i.accept && opcode_i == OP_GET && id_valid) begin
      ram_re    = 1'b1;
      ram_raddr = timer_id_i[ADDR_W-1:0];
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = wb_idx_q;
    ram_wdata = entry_value - DATA_W'(1);
    if (wb_valid_q && entry_value != '0) begin
      ram_we = 1'b1;
    end else if (cmd_i.accept && opcode_i == OP_SET && id_valid) begin
      ram_we    = 1'b1;
      ram_waddr = timer_id_i[ADDR_W-1:0];
      ram_wdata = write_value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      cnt_q      <= '0;
      wb_valid_q <= 1'b0;
      wb_idx_q   <= '0;
      rvalid_q   <= 1'b0;
      op_q       <= OP_TICK;
      idv_q      <= 1'b0;
    end else begin
      if (ram_we) begin
        valid_q[ram_waddr] <= 1'b1;
      end
      if (ram_re) begin
        rvalid_q <= valid_q[ram_raddr];
      end
      if (cmd_i.accept) begin
        cnt_q <= '0;
        op_q  <= opcode_i;
        idv_q <= id_valid;
      end else if (sweep_issue) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
      wb_valid_q <= sweep_issue;
      wb_idx_q   <= cnt_q[ADDR_W-1:0];
    end
  end

  stb_ram #(
    .WIDTH (DATA_W),
    .DEPTH (NUM_TIMERS)
  ) u_timers (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign status_o.is_tick    = opcode_i == OP_TICK;
  assign status_o.sweep_done = (cnt_q == CNT_W'(NUM_TIMERS)) && !wb_valid_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ok_q          <= (op_q == OP_TICK) || ((op_q == OP_SET || op_q == OP_GET) && idv_q);
      read_value_q  <= (op_q == OP_GET && idv_q) ? entry_value : '0;
      action_due_q  <= (op_q == OP_TICK) && due_q;
      seconds_out_q <= seconds_q;
      ticks_out_q   <= ticks_q;
    end
  end

  assign ok_o            = ok_q;
  assign read_value_o    = read_value_q;
  assign action_due_o    = action_due_q;
  assign seconds_count_o = seconds_out_q;
  assign tick_count_o    = ticks_out_q;

endmodule

>>> rtl/soft_timer_bank.sv
// Bank of millisecond down-counters. A tick sweeps the timers between acceptance and
// result, doing one RAM read and write-back per cycle; set and get skip the sweep.
// One item is in flight at a time: no new item is taken until the last result is
// loaded into the output register.
// Reset (rst_ni low, asynchronous) clears all counts, marks every timer zero through
// per-entry valid bits and returns the action period to 10; there is no clearing pass.
module soft_timer_bank #(
  parameter int unsigned NUM_TIMERS = 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [stb_pkg::CFG_W-1:0]          cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [1:0]                         opcode_i,
  input  logic [stb_pkg::ID_W-1:0]           timer_id_i,
  input  logic [stb_pkg::DATA_W-1:0]         write_value_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic                               ok_o,
  output logic [stb_pkg::DATA_W-1:0]         read_value_o,
  output logic                               action_due_o,
  output logic [stb_pkg::DATA_W-1:0]         seconds_count_o,
  output logic [stb_pkg::DATA_W-1:0]         tick_count_o
);

  import stb_pkg::*;

  stb_cmd_t    cmd;
  stb_status_t status;

  stb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  stb_datapath #(
    .NUM_TIMERS (NUM_TIMERS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .opcode_i        (opcode_i),
    .timer_id_i      (timer_id_i),
    .write_value_i   (write_value_i),
    .cmd_i           (cmd),
    .status_o        (status),
    .ok_o            (ok_o),
    .read_value_o    (read_value_o),
    .action_due_o    (action_due_o),
    .seconds_count_o (seconds_count_o),
    .tick_count_o    (tick_count_o)
  );

`ifndef ASSERT_OFF
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second transaction accepted while one is in progress");

  a_fail_reads_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !ok_o |-> read_value_o == '0)
    else $error("failed result carries a nonzero read value");

  a_due_implies_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && action_due_o |-> ok_o)
    else $error("action due flagged on a result that is not an accepted tick");
`endif

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import stb_pkg::*;

  localparam int unsigned NUM_TIMERS   = 8;
  localparam logic [1:0]  OP_NONE      = 2'd3;
  localparam int unsigned RESET_CYCLES = 12;
  localparam int unsigned STALL_LIMIT  = 3000;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned PHASES       = 6;
  localparam int unsigned PHASE_ITEMS  = 225;

  typedef struct packed {
    logic              ok;
    logic [DATA_W-1:0] read_value;
    logic              action_due;
    logic [DATA_W-1:0] seconds_count;
    logic [DATA_W-1:0] tick_count;
  } timer_result_t;

  class timer_tracker;
    logic [DATA_W-1:0]   timers [NUM_TIMERS];
    logic [PRE_W-1:0]    prescale;
    logic [MILLIS_W-1:0] millis;
    logic [DATA_W-1:0]   seconds;
    logic [DATA_W-1:0]   ticks;
    logic [CFG_W-1:0]    period;
    timer_result_t       pending_results [$];
    int unsigned         errors;

    function new();
      foreach (timers[k]) timers[k] = '0;
      prescale = '0;
      millis   = '0;
      seconds  = '0;
      ticks    = '0;
      period   = PERIOD_RESET;
      errors   = 0;
    endfunction

    task report(string msg);
      $display("ERROR at %0t: %s", $time, msg);
      errors++;
    endtask

    // Applies one accepted transaction to the tracked state and queues its result.
    function void note_op(logic [1:0] op, logic [ID_W-1:0] id, logic [DATA_W-1:0] wval);
      timer_result_t res;
      int unsigned   span;
      res = '0;
      case (op)
        OP_TICK: begin
          span = (period == 0) ? 1 : ((period > PERIOD_MAX) ? PERIOD_MAX : period);
          ticks++;
          // A prescale at or above the period, e.g. after the period was lowered,
          // pulses at once.
          if (prescale < span - 1) begin
            prescale++;
          end else begin
            res.action_due = 1'b1;
            prescale = '0;
          end
          if (millis >= MILLIS_WRAP) begin
            millis = '0;
            seconds++;
          end else begin
            millis++;
          end
          foreach (timers[k]) if (timers[k] != 0) timers[k]--;
          res.ok = 1'b1;
        end
        OP_SET: begin
          if (id < NUM_TIMERS) begin
            timers[id] = wval;
            res.ok = 1'b1;
          end
        end
        OP_GET: begin
          if (id < NUM_TIMERS) begin
            res.read_value = timers[id];
            res.ok = 1'b1;
          end
        end
        default: ;
      endcase
      res.seconds_count = seconds;
      res.tick_count    = ticks;
      pending_results.push_back(res);
    endfunction

    task check_result(logic ok, logic [DATA_W-1:0] rd, logic due, logic [DATA_W-1:0] sec,
                      logic [DATA_W-1:0] tk);
      timer_result_t exp_res;
      if (pending_results.size() == 0) begin
        report("result transaction with no expected result pending");
      end else begin
        exp_res = pending_results.pop_front();
        if (ok !== exp_res.ok)
          report($sformatf("ok: got %b, expected %b", ok, exp_res.ok));
        if (rd !== exp_res.read_value)
          report($sformatf("read_value: got %h, expected %h", rd, exp_res.read_value));
        if (due !== exp_res.action_due)
          report($sformatf("action_due: got %b, expected %b", due, exp_res.action_due));
        if (sec !== exp_res.seconds_count)
          report($sformatf("seconds_count: got %0d, expected %0d", sec,
                           exp_res.seconds_count));
        if (tk !== exp_res.tick_count)
          report($sformatf("tick_count: got %0d, expected %0d", tk, exp_res.tick_count));
      end
    endtask
  endclass

  logic              clk = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we = 1'b0;
  logic [CFG_W-1:0]  cfg_wdata = '0;
  logic              in_valid = 1'b0;
  logic [1:0]        opcode = OP_TICK;
  logic [ID_W-1:0]   timer_id = '0;
  logic [DATA_W-1:0] write_value = '0;
  logic              out_ready = 1'b0;
  logic              in_ready_o;
  logic              out_valid_o;
  logic              ok_o;
  logic [DATA_W-1:0] read_value_o;
  logic              action_due_o;
  logic [DATA_W-1:0] seconds_count_o;
  logic [DATA_W-1:0] tick_count_o;

  int unsigned sender_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_left = 0;
  int unsigned quiet_cycles = 0;

  timer_tracker tracker;

  soft_timer_bank #(
    .NUM_TIMERS(NUM_TIMERS)
  ) i_dut (
    .clk_i          (clk),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready_o),
    .opcode_i       (opcode),
    .timer_id_i     (timer_id),
    .write_value_i  (write_value),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready),
    .ok_o           (ok_o),
    .read_value_o   (read_value_o),
    .action_due_o   (action_due_o),
    .seconds_count_o(seconds_count_o),
    .tick_count_o   (tick_count_o)
  );

  always #1 clk = ~clk;

  // The receiver stalls at random, or for a long stretch when hold_left is loaded.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready = 1'b0;
      hold_left--;
    end else begin
      out_ready = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_ni && out_valid_o && out_ready)
      tracker.check_result(ok_o, read_value_o, action_due_o, seconds_count_o, tick_count_o);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready_o) || (out_valid_o && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  task automatic send_op(input logic [1:0] op, input logic [ID_W-1:0] id,
                         input logic [DATA_W-1:0] wval);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid    = 1'b1;
    opcode      = op;
    timer_id    = id;
    write_value = wval;
    do @(posedge clk); while (!in_ready_o);
    tracker.note_op(op, id, wval);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (tracker.pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic write_period(input logic [CFG_W-1:0] value);
    cfg_we    = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
    tracker.period = value;
  endtask

  initial begin
    int unsigned       pick;
    logic [1:0]        op;
    logic [ID_W-1:0]   id;
    logic [DATA_W-1:0] wval;
    logic [CFG_W-1:0]  period;

    tracker = new();
    repeat (RESET_CYCLES) @(negedge clk);
    rst_ni = 1'b1;
    @(negedge clk);

    // Directed part under the reset period.
    send_op(OP_GET, 8'd0, '0);
    send_op(OP_SET, 8'd0, 32'd3);
    send_op(OP_SET, 8'd7, 32'hFFFF_FFFF);
    send_op(OP_SET, 8'd8, 32'd5);
    send_op(OP_SET, 8'd255, 32'hA5A5_5A5A);
    send_op(OP_GET, 8'd255, 32'hFFFF_FFFF);
    send_op(OP_NONE, 8'd0, 32'd1);
    send_op(OP_GET, 8'd7, '0);
    // Five ticks: timer 0 runs down to zero and stays there.
    repeat (5) send_op(OP_TICK, 8'd0, '0);
    send_op(OP_GET, 8'd0, '0);
    send_op(OP_GET, 8'd7, '0);

    // The period drops below the current prescale, so the next tick pulses.
    drain();
    write_period(9'd2);
    repeat (3) send_op(OP_TICK, 8'd1, '0);
    drain();
    write_period(9'd0);
    repeat (2) send_op(OP_TICK, 8'd2, '0);
    drain();
    write_period(9'd511);
    send_op(OP_SET, 8'd3, '0);
    send_op(OP_GET, 8'd3, '0);
    send_op(OP_TICK, 8'd255, 32'hFFFF_FFFF);
    send_op(OP_SET, 8'd6, 32'd1);

    for (int p = 0; p < PHASES; p++) begin
      drain();
      case (p)
        0: period = 9'd1;
        1: period = 9'd256;
        2: period = 9'd511;
        3: period = 9'd3;
        4: period = 9'd0;
        default: period = CFG_W'($urandom_range(1, 511));
      endcase
      write_period(period);
      if (p < 2) begin
        sender_idle_pct = 29;
        recv_idle_pct   = 60;
      end else if (p < 4) begin
        sender_idle_pct = 60;
        recv_idle_pct   = 29;
      end else begin
        sender_idle_pct = 0;
        recv_idle_pct   = 0;
      end
      // Long receiver stall while the sender keeps offering transactions.
      if (p == 1) hold_left = HOLD_CYCLES;

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(99);
        if (pick < 80) op = OP_TICK;
        else if (pick < 89) op = OP_SET;
        else if (pick < 98) op = OP_GET;
        else op = OP_NONE;
        id   = ($urandom_range(99) < 85) ? ID_W'($urandom_range(NUM_TIMERS - 1))
                                         : ID_W'($urandom_range(255));
        wval = ($urandom_range(3) == 0) ? $urandom : $urandom_range(40);
        send_op(op, id, wval);
      end
    end

    drain();
    repeat (2 * NUM_TIMERS + 8) @(negedge clk);
    if (tracker.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
